>>> hdl/numeric_literal_scanner_assert.svh
// assertion macros shared by the numeric literal scanner modules
`ifndef NUMERIC_LITERAL_SCANNER_ASSERT_SVH
`define NUMERIC_LITERAL_SCANNER_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define NLS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while in reset
`define NLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/nls_pkg.sv
// types, constants and digit helpers for the numeric literal scanner
`timescale 1ns / 1ps

package nls_pkg;

  localparam logic [7:0] CHAR_X   = 8'h78;
  localparam logic [7:0] CHAR_DOT = 8'h2E;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_ZERO  = 3'd1,
    PH_HEXP  = 3'd2,
    PH_WHOLE = 3'd3,
    PH_FRAC  = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    KIND_INT      = 2'd0,
    KIND_FLOAT    = 2'd1,
    KIND_MISMATCH = 2'd2,
    KIND_ERROR    = 2'd3
  } kind_e;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } digit_t;

  typedef struct packed {
    logic        emit;
    kind_e       kind;
    logic [63:0] whole;
    logic [63:0] frac;
    logic [7:0]  count;
    logic        hex;
  } step_res_t;

  function automatic digit_t digit_of(logic [7:0] ch, logic is_hex);
    digit_t r;
    r.ok  = 1'b0;
    r.val = 4'd0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      r.ok  = 1'b1;
      r.val = ch[3:0];
    end else if (is_hex && ((ch >= 8'h61 && ch <= 8'h66) ||
                            (ch >= 8'h41 && ch <= 8'h46))) begin
      // low nibble of 'a' and 'A' is 1, so add 9 to get 10..15
      r.ok  = 1'b1;
      r.val = ch[3:0] + 4'd9;
    end
    return r;
  endfunction

  // acc * base + d, base 16 by shift, base 10 as 8x + 2x
  function automatic logic [63:0] push_digit(logic [63:0] acc, logic [3:0] d,
                                             logic is_hex);
    logic [63:0] r;
    if (is_hex) begin
      r = {acc[59:0], d};
    end else begin
      r = (acc << 3) + (acc << 1) + {60'd0, d};
    end
    return r;
  endfunction

endpackage

>>> hdl/nls_if.sv
// stream interfaces for the character input and the token output
`timescale 1ns / 1ps

interface nls_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

interface nls_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  token_kind;
  logic [63:0] whole_value;
  logic [63:0] fraction_value;
  logic [7:0]  fraction_digit_count;
  logic        base_is_hex;

  modport source (output valid, output token_kind, output whole_value,
                  output fraction_value, output fraction_digit_count,
                  output base_is_hex, input ready);
  modport sink   (input valid, input token_kind, input whole_value,
                  input fraction_value, input fraction_digit_count,
                  input base_is_hex, output ready);
endinterface

>>> hdl/numeric_literal_scanner.sv
// Numeric literal scanner: takes one character per transfer and returns one token
// per literal (integer, float, mismatch or missing hex digit) with whole part,
// fraction digits as an integer, fraction digit count and base. Each character is
// scanned between the input register and the result register, so one character is
// taken every cycle, and the input is held only while a finished token waits. A
// token is registered as the character ending it is scanned. The multiply by 10
// or 16 of the 64-bit accumulator is the longest path.
`timescale 1ns / 1ps
`include "numeric_literal_scanner_assert.svh"

module numeric_literal_scanner (
  input  logic      clk_i,
  input  logic      rst_ni,
  nls_in_if.sink    in_i,
  nls_out_if.source out_o
);
  import nls_pkg::*;

  logic        in_valid_q;
  logic [7:0]  in_char_q;
  logic        in_eot_q;
  logic        in_ready;
  logic        out_free;
  logic        step_en;
  step_res_t   res;

  logic        out_valid_q;
  kind_e       out_kind_q;
  logic [63:0] out_whole_q;
  logic [63:0] out_frac_q;
  logic [7:0]  out_count_q;
  logic        out_hex_q;

  assign out_free = !out_valid_q || out_o.ready;
  assign step_en  = in_valid_q && out_free;
  assign in_ready = !in_valid_q || step_en;
  assign in_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      in_char_q <= in_i.char_code;
      in_eot_q  <= in_i.end_of_text;
    end
  end

  nls_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_en_i     (step_en),
    .char_code_i   (in_char_q),
    .end_of_text_i (in_eot_q),
    .res_o         (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step_en && res.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en && res.emit) begin
      out_kind_q  <= res.kind;
      out_whole_q <= res.whole;
      out_frac_q  <= res.frac;
      out_count_q <= res.count;
      out_hex_q   <= res.hex;
    end
  end

  assign out_o.valid                = out_valid_q;
  assign out_o.token_kind           = out_kind_q;
  assign out_o.whole_value          = out_whole_q;
  assign out_o.fraction_value       = out_frac_q;
  assign out_o.fraction_digit_count = out_count_q;
  assign out_o.base_is_hex          = out_hex_q;

  `NLS_ASSERT_NOW(a_mismatch_clear, out_valid_q && out_kind_q == KIND_MISMATCH,
                  out_whole_q == 64'd0 && out_frac_q == 64'd0 &&
                  out_count_q == 8'd0 && !out_hex_q,
                  "mismatch token carries non-zero fields")
  `NLS_ASSERT_NOW(a_error_is_hex, out_valid_q && out_kind_q == KIND_ERROR,
                  out_hex_q && out_whole_q == 64'd0 && out_count_q == 8'd0,
                  "missing hex digit token malformed")
  `NLS_ASSERT_NOW(a_int_no_fraction, out_valid_q && out_kind_q == KIND_INT,
                  out_frac_q == 64'd0 && out_count_q == 8'd0,
                  "integer token carries fraction fields")

endmodule

>>> hdl/nls_core.sv
// scan state and per-character step logic of the numeric literal scanner
`timescale 1ns / 1ps
`include "numeric_literal_scanner_assert.svh"

module nls_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_en_i,
  input  logic [7:0]        char_code_i,
  input  logic              end_of_text_i,
  output nls_pkg::step_res_t res_o
);
  import nls_pkg::*;

  phase_e      phase_q, phase_d;
  logic        hex_q, hex_d;
  logic [63:0] whole_q, whole_d;
  logic [63:0] frac_q, frac_d;
  logic [7:0]  count_q, count_d;

  digit_t    dig_cur;
  digit_t    dig_dec;
  digit_t    dig_hex;
  logic      is_x;
  logic      is_dot;
  step_res_t res;

  always_comb begin
    dig_cur = digit_of(char_code_i, hex_q);
    dig_dec = digit_of(char_code_i, 1'b0);
    dig_hex = digit_of(char_code_i, 1'b1);
    // end of text is never a digit or a dot
    dig_cur.ok = dig_cur.ok & ~end_of_text_i;
    dig_dec.ok = dig_dec.ok & ~end_of_text_i;
    dig_hex.ok = dig_hex.ok & ~end_of_text_i;
    is_x   = !end_of_text_i && (char_code_i == CHAR_X);
    is_dot = !end_of_text_i && (char_code_i == CHAR_DOT);
  end

  always_comb begin
    phase_d   = phase_q;
    hex_d     = hex_q;
    whole_d   = whole_q;
    frac_d    = frac_q;
    count_d   = count_q;
    res.emit  = 1'b0;
    res.kind  = KIND_INT;
    res.whole = 64'd0;
    res.frac  = 64'd0;
    res.count = 8'd0;
    res.hex   = 1'b0;
    case (phase_q)
      PH_ZERO, PH_WHOLE: begin
        if (phase_q == PH_ZERO && is_x) begin
          hex_d   = 1'b1;
          phase_d = PH_HEXP;
        end else if (dig_cur.ok) begin
          whole_d = push_digit(whole_q, dig_cur.val, hex_q);
          phase_d = PH_WHOLE;
        end else if (is_dot) begin
          frac_d  = 64'd0;
          count_d = 8'd0;
          phase_d = PH_FRAC;
        end else begin
          res.emit  = 1'b1;
          res.kind  = KIND_INT;
          res.whole = whole_q;
          res.hex   = hex_q;
          phase_d   = PH_IDLE;
        end
      end
      PH_HEXP: begin
        if (dig_hex.ok) begin
          whole_d = {60'd0, dig_hex.val};
          phase_d = PH_WHOLE;
        end else begin
          res.emit = 1'b1;
          res.kind = KIND_ERROR;
          res.hex  = 1'b1;
          phase_d  = PH_IDLE;
        end
      end
      PH_FRAC: begin
        if (dig_cur.ok) begin
          frac_d = push_digit(frac_q, dig_cur.val, hex_q);
          if (count_q != 8'hFF) begin
            count_d = count_q + 8'd1;
          end
        end else begin
          res.emit  = 1'b1;
          res.kind  = KIND_FLOAT;
          res.whole = whole_q;
          res.frac  = frac_q;
          res.count = count_q;
          res.hex   = hex_q;
          phase_d   = PH_IDLE;
        end
      end
      default: begin
        // idle, and the unreachable codes behave the same
        if (!dig_dec.ok) begin
          res.emit = 1'b1;
          res.kind = KIND_MISMATCH;
          phase_d  = PH_IDLE;
        end else begin
          hex_d   = 1'b0;
          whole_d = {60'd0, dig_dec.val};
          frac_d  = 64'd0;
          count_d = 8'd0;
          phase_d = (dig_dec.val == 4'd0) ? PH_ZERO : PH_WHOLE;
        end
      end
    endcase
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      hex_q   <= 1'b0;
      whole_q <= 64'd0;
      frac_q  <= 64'd0;
      count_q <= 8'd0;
    end else if (step_en_i) begin
      phase_q <= phase_d;
      hex_q   <= hex_d;
      whole_q <= whole_d;
      frac_q  <= frac_d;
      count_q <= count_d;
    end
  end

  `NLS_ASSERT_NEXT(a_hex_after_prefix, step_en_i && phase_q == PH_HEXP, hex_q,
                   "hex mode lost after 0x prefix")
  `NLS_ASSERT_NEXT(a_idle_after_token, step_en_i && res.emit, phase_q == PH_IDLE,
                   "scanner not idle after a token")

endmodule
